// File: design/knr_pkg.sv
// Shared types and constants for the K-out-of-N reliability block.
`timescale 1ns / 1ps
package knr_pkg;

  localparam int VAL_W  = 17;
  localparam int KCFG_W = 6;
  localparam int PROD_W = 2 * VAL_W;

  localparam logic [VAL_W-1:0]  ONE_Q16  = 17'd65536;
  localparam logic [PROD_W:0]   HALF_Q16 = 35'd32768;

  localparam int ITEM_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH  = 2;

  // Register index taken from paddr[2]
  localparam logic REG_MIN_WORKING = 1'b0;

  typedef struct packed {
    logic [VAL_W-1:0]  p;
    logic [VAL_W-1:0]  q;
    logic [KCFG_W-1:0] k;
    logic              last;
  } knr_item_t;

  // Clamp a widened Q1.16 value to 1.0
  function automatic logic [VAL_W-1:0] sat_q16(input logic [VAL_W+1:0] v);
    logic [VAL_W-1:0] r;
    if (v > {2'b00, ONE_Q16}) r = ONE_Q16;
    else r = v[VAL_W-1:0];
    return r;
  endfunction

endpackage

// File: design/knr_fifo.sv
// Small register-based queue with registered storage and count-based flags.
`timescale 1ns / 1ps
module knr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// File: design/knr_front.sv
// Front end: configuration register, input acceptance and item classification.
`timescale 1ns / 1ps
module knr_front import knr_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              push,
  output logic              full,
  input  logic [VAL_W-1:0]  in_component_reliability,
  input  logic              in_last_component,
  // item queue side
  input  logic              item_full,
  output logic              item_wr,
  output knr_item_t         item_data
);

  logic [KCFG_W-1:0] min_working_r, min_working_nxt;
  logic              reg_hit;
  logic [VAL_W-1:0]  p_sat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_MIN_WORKING);
  assign prdata  = reg_hit ? {{(32-KCFG_W){1'b0}}, min_working_r} : '0;

  always_comb begin
    min_working_nxt = min_working_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      min_working_nxt = pwdata[KCFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_working_r <= KCFG_W'(1);
    end else begin
      min_working_r <= min_working_nxt;
    end
  end

  // Clamp p to 1.0 and K to the table size
  assign p_sat = (in_component_reliability > ONE_Q16) ? ONE_Q16 : in_component_reliability;

  always_comb begin
    item_data.p    = p_sat;
    item_data.q    = ONE_Q16 - p_sat;
    item_data.last = in_last_component;
    if ({{(32-KCFG_W){1'b0}}, min_working_r} > 32'(MAX_K)) begin
      item_data.k = KCFG_W'(MAX_K);
    end else begin
      item_data.k = min_working_r;
    end
  end

  assign full    = item_full;
  assign item_wr = push && !item_full;

endmodule

// File: design/knr_back.sv
// Back end: parallel update of the capped working-count distribution.
`timescale 1ns / 1ps
module knr_back import knr_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  knr_item_t        item_data,
  input  logic             item_empty,
  output logic             item_rd,
  input  logic             res_full,
  output logic             res_wr,
  output logic [VAL_W-1:0] res_data
);

  localparam int KW = $clog2(MAX_K + 1);

  logic [VAL_W-1:0] prob_r   [MAX_K+1];
  logic [VAL_W-1:0] prob_nxt [MAX_K+1];
  logic [KW-1:0]    k_idx;

  assign k_idx = KW'(item_data.k);

  // Hold a closing item until the result queue has room
  assign item_rd  = !item_empty && (!item_data.last || !res_full);
  assign res_wr   = item_rd && item_data.last;
  assign res_data = prob_nxt[k_idx];

  for (genvar g = 0; g <= MAX_K; g++) begin : g_lane
    localparam logic [KW-1:0] IDX = KW'(g);
    logic [VAL_W-1:0]  below;
    logic [PROD_W-1:0] pb, qh;
    logic [PROD_W:0]   mix_sum, pb_rnd;
    logic [VAL_W+1:0]  mix_val, absorb_val;

    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_rest
      assign below = prob_r[g-1];
    end

    assign pb      = item_data.p * below;
    assign qh      = item_data.q * prob_r[g];
    assign mix_sum = {1'b0, pb} + {1'b0, qh} + HALF_Q16;
    assign pb_rnd  = {1'b0, pb} + HALF_Q16;
    assign mix_val = mix_sum[PROD_W:16];
    // Rounded product never exceeds 1.0, so 17 bits carry it
    assign absorb_val = {2'b00, prob_r[g]} + {2'b00, pb_rnd[VAL_W+15:16]};

    always_comb begin
      if (IDX < k_idx) prob_nxt[g] = sat_q16(mix_val);
      else if (IDX == k_idx) prob_nxt[g] = sat_q16(absorb_val);
      else prob_nxt[g] = prob_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_K; i++) begin
        prob_r[i] <= (i == 0) ? ONE_Q16 : '0;
      end
    end else if (item_rd) begin
      for (int i = 0; i <= MAX_K; i++) begin
        if (item_data.last) prob_r[i] <= (i == 0) ? ONE_Q16 : '0;
        else prob_r[i] <= prob_nxt[i];
      end
    end
  end

endmodule

// File: design/k_of_n_reliability_mixed.sv
// Top level of the K-out-of-N system reliability block.
// A closing item passes through the item queue and the back end into the result queue,
// unless the result queue is full; then the closing item waits in the item queue.
// Throughput: one item per cycle while no closing item waits on a full result queue;
// every distribution entry is updated by its own multiply-add lane, so the lane update sets the rate.
// Reset: K returns to 1, the distribution to entry 0 = 1.0 and all others 0,
// and both queues empty.
`timescale 1ns / 1ps
module k_of_n_reliability_mixed import knr_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  logic [VAL_W-1:0] in_component_reliability,
  input  logic             in_last_component,
  output logic             empty,
  input  logic             pop,
  output logic [VAL_W-1:0] out_system_reliability
);

  localparam int IW = $bits(knr_item_t);

  logic             item_wr, item_rd, item_full, item_empty;
  knr_item_t        item_in, item_out;
  logic [IW-1:0]    item_out_bits;
  logic             res_wr, res_full;
  logic [VAL_W-1:0] res_data;

  knr_front #(.MAX_K(MAX_K)) u_front (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .in_component_reliability, .in_last_component,
    .item_full, .item_wr, .item_data(item_in)
  );

  knr_fifo #(.WIDTH(IW), .DEPTH(ITEM_Q_DEPTH)) u_item_q (
    .clk, .rst_n,
    .wr_en(item_wr), .wr_data(item_in),
    .rd_en(item_rd), .rd_data(item_out_bits),
    .full(item_full), .empty(item_empty)
  );

  assign item_out = knr_item_t'(item_out_bits);

  knr_back #(.MAX_K(MAX_K)) u_back (
    .clk, .rst_n,
    .item_data(item_out), .item_empty, .item_rd,
    .res_full, .res_wr, .res_data
  );

  knr_fifo #(.WIDTH(VAL_W), .DEPTH(RES_Q_DEPTH)) u_res_q (
    .clk, .rst_n,
    .wr_en(res_wr), .wr_data(res_data),
    .rd_en(pop), .rd_data(out_system_reliability),
    .full(res_full), .empty(empty)
  );

  a_res_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_system_reliability <= ONE_Q16))
    else $error("result above 1.0");

  a_no_res_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (item_rd && item_out.last) |-> !res_full)
    else $error("closing item retired while result queue full");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !item_empty |-> ({26'b0, item_out.k} <= 32'(MAX_K)))
    else $error("queued K above table size");

endmodule

// File: test/knr_checker.sv
// Checker: predicts and checks K-out-of-N reliability results from the item and register traffic.
`timescale 1ns / 1ps
module knr_checker import knr_pkg::*; #(
  parameter int MAX_K = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  input  logic             push,
  input  logic             full,
  input  logic [VAL_W-1:0] in_component_reliability,
  input  logic             in_last_component,
  input  logic             empty,
  input  logic             pop,
  input  logic [VAL_W-1:0] out_system_reliability,
  output int               outstanding,
  output int               fail_count,
  output int               results_seen
);

  localparam int PRINT_CAP = 50;

  logic [KCFG_W-1:0] min_working;
  logic [VAL_W-1:0]  count_prob [0:MAX_K];
  logic [VAL_W-1:0]  expected_reliability_q [$];

  initial begin
    outstanding  = 0;
    fail_count   = 0;
    results_seen = 0;
  end

  function automatic logic [VAL_W-1:0] clamp_one(input longint unsigned v);
    return (v > ONE_Q16) ? ONE_Q16 : VAL_W'(v);
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic clear_distribution();
    foreach (count_prob[j]) count_prob[j] = '0;
    count_prob[0] = ONE_Q16;
  endtask

  // Fold one component into the working-count distribution, capped at K
  task automatic fold_component(input logic [VAL_W-1:0] p_raw, input logic last);
    logic [VAL_W-1:0] nxt [0:MAX_K];
    longint unsigned p, q, below, here, acc;
    int kk;
    p  = (p_raw > ONE_Q16) ? ONE_Q16 : p_raw;
    q  = ONE_Q16 - p;
    kk = (min_working > MAX_K) ? MAX_K : min_working;
    nxt = count_prob;
    for (int j = 0; j <= kk; j++) begin
      below = 0;
      if (j > 0) below = count_prob[j-1];
      here = count_prob[j];
      // entry K absorbs: at least K components work
      if (j == kk) acc = here + ((p * below + HALF_Q16) >> 16);
      else acc = (p * below + q * here + HALF_Q16) >> 16;
      nxt[j] = clamp_one(acc);
    end
    count_prob = nxt;
    if (last) begin
      expected_reliability_q.push_back(count_prob[kk]);
      clear_distribution();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      min_working = 6'd1;
      clear_distribution();
      expected_reliability_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_WORKING)
        min_working = pwdata[KCFG_W-1:0];
      // check the popped item before folding in the one pushed at the same edge
      if (pop && !empty) begin
        results_seen++;
        if (expected_reliability_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_system_reliability));
        end else begin
          if (out_system_reliability !== expected_reliability_q[0])
            report_mismatch($sformatf("system_reliability got %0d expected %0d",
                                      out_system_reliability, expected_reliability_q[0]));
          void'(expected_reliability_q.pop_front());
        end
      end
      if (push && !full) fold_component(in_component_reliability, in_last_component);
    end
    outstanding <= expected_reliability_q.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top import knr_pkg::*;;

  localparam int MAX_K         = 32;
  localparam int ITEM_TARGET   = 1720;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam logic [2:0] MIN_WORKING_ADDR = {REG_MIN_WORKING, 2'b00};

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             push;
  logic             full;
  logic [VAL_W-1:0] in_component_reliability;
  logic             in_last_component;
  logic             empty;
  logic             pop;
  logic [VAL_W-1:0] out_system_reliability;

  int outstanding;
  int fail_count;
  int results_seen;
  int items_sent;
  int k_writes;
  int burst_left;
  int idle_cycles;
  bit hold_request;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  k_of_n_reliability_mixed #(.MAX_K(MAX_K)) u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready),
    .push                     (push),
    .full                     (full),
    .in_component_reliability (in_component_reliability),
    .in_last_component        (in_last_component),
    .empty                    (empty),
    .pop                      (pop),
    .out_system_reliability   (out_system_reliability)
  );

  knr_checker #(.MAX_K(MAX_K)) u_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .pready                   (pready),
    .push                     (push),
    .full                     (full),
    .in_component_reliability (in_component_reliability),
    .in_last_component        (in_last_component),
    .empty                    (empty),
    .pop                      (pop),
    .out_system_reliability   (out_system_reliability),
    .outstanding              (outstanding),
    .fail_count               (fail_count),
    .results_seen             (results_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall density changes every so often; a long hold-off on request
  initial begin : receiver
    int stall_pct;
    int hold_left;
    int rx_cycle;
    stall_pct = 0;
    hold_left = 0;
    rx_cycle  = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 150 == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 30;
          2: stall_pct = 70;
          default: stall_pct = 92;
        endcase
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper data bits carry noise; only the low K field matters
  task automatic set_k(input int k);
    logic [31:0] word;
    word = $urandom;
    word[KCFG_W-1:0] = KCFG_W'(k);
    write_reg(MIN_WORKING_ADDR, word);
    k_writes++;
  endtask

  task automatic send_item(input logic [VAL_W-1:0] p, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_component_reliability <= p;
    in_last_component        <= last;
    push <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Hold the sender until every expected result is out
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_reliability();
    case ($urandom_range(9))
      0: return '0;
      1: return ONE_Q16;
      2: return VAL_W'($urandom_range(65537, 131071));
      3, 4, 5: return VAL_W'($urandom_range(58000, 65536));
      default: return VAL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // One time instant with a component count around K
  task automatic send_instant(input int k_eff);
    int n;
    if (k_eff > 3) n = $urandom_range(k_eff - 3, k_eff + 3);
    else n = $urandom_range(1, k_eff + 4);
    for (int i = 1; i <= n; i++) send_item(pick_reliability(), i == n);
  endtask

  initial begin : stimulus
    int phase;
    int k;
    int k_eff;
    int phase_items;
    int first_ks [6];
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    in_component_reliability = '0;
    in_last_component = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    k_writes = 0;
    burst_left = 0;
    idle_cycles = 0;
    first_ks = '{2, 32, 63, 0, 33, 1};
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // K at its reset value: extremes and reliability above one
    send_item('0, 1'b1);
    send_item(ONE_Q16, 1'b1);
    send_item(17'h1FFFF, 1'b1);
    send_item(17'd32768, 1'b0);
    send_item(17'd32768, 1'b1);
    // fewer components than K, then mixed values
    settle();
    set_k(3);
    send_item(ONE_Q16, 1'b0);
    send_item(ONE_Q16, 1'b1);
    send_item(17'h15555, 1'b0);
    send_item(17'h0AAAA, 1'b0);
    send_item(17'd50000, 1'b0);
    send_item(17'd65535, 1'b1);
    // K of zero always gives 1.0
    settle();
    set_k(0);
    send_item(17'd12345, 1'b0);
    send_item('0, 1'b1);
    // K above the lane count saturates
    settle();
    set_k(63);
    send_item(ONE_Q16, 1'b0);
    send_item(ONE_Q16, 1'b0);
    send_item(ONE_Q16, 1'b1);
    // K changed inside an instant
    settle();
    set_k(2);
    send_item(17'd40000, 1'b0);
    send_item(17'd50000, 1'b0);
    settle();
    set_k(1);
    send_item(17'd30000, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 6) begin
        k = first_ks[phase];
      end else begin
        case ($urandom_range(9))
          0: k = 0;
          1: k = $urandom_range(33, 63);
          2: k = MAX_K;
          default: k = $urandom_range(1, 16);
        endcase
      end
      k_eff = (k > MAX_K) ? MAX_K : k;
      settle();
      set_k(k);
      // fill the block while the receiver holds off
      if (phase == 0) hold_request = 1'b1;
      phase_items = items_sent;
      while (items_sent - phase_items < 100) begin
        send_instant(k_eff);
        if (phase == 3 && items_sent - phase_items < 40) drain();
      end
      // leave the instant open so the next K applies mid-instant
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(pick_reliability(), 1'b0);
      end
      phase++;
    end

    settle();
    @(negedge clk);
    $display("Run covered %0d components and %0d checked results over %0d K settings,",
             items_sent, results_seen, k_writes);
    $display("with K of zero, K above range, reliabilities above one and mid-instant K changes.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
